>>> design/cad_pkg.sv
// Package for the calculator address decoder: access, source, model and register codes,
// address constants and the configuration and result structures.
// Used by cad_decode and calculator_address_decoder_core.
`default_nettype none

package cad_pkg;

    // Access kinds carried on the input side band
    localparam logic [1:0] OP_FETCH    = 2'd0;
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_WRITE    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Where the access is served from
    localparam logic [1:0] SRC_CONST = 2'd0;
    localparam logic [1:0] SRC_ROM   = 2'd1;
    localparam logic [1:0] SRC_FLASH = 2'd2;
    localparam logic [1:0] SRC_BUS   = 2'd3;

    // Hardware models: es_plus, ti, classwiz, classwiz_ii and the flash-based model
    localparam logic [2:0] MDL_ESP   = 3'd0;
    localparam logic [2:0] MDL_TI    = 3'd1;
    localparam logic [2:0] MDL_CWZ   = 3'd2;
    localparam logic [2:0] MDL_CWZ2  = 3'd3;
    localparam logic [2:0] MDL_FLASH = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_HW_MODEL       = 3'd0;
    localparam logic [2:0] REG_BOOT_REMAP     = 3'd1;
    localparam logic [2:0] REG_SEGMENT_ACCESS = 3'd2;
    localparam logic [2:0] REG_ROM_BYTES      = 3'd3;
    localparam logic [2:0] REG_REAL_HW_MODE   = 3'd4;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 21;

    // Reset value of the ROM size register (256 KiB)
    localparam logic [20:0] ROM_BYTES_RESET = 21'h040000;

    // Address constants
    localparam logic [15:0] BOOT_REMAP_OFS  = 16'hFE00;
    localparam logic [15:0] BOOT_REMAP_SPAN = 16'h0200;
    localparam logic [19:0] SEG7_ROM_BASE   = 20'h5E000;
    localparam logic [15:0] SEG7_LIMIT      = 16'h2000;
    localparam logic [15:0] SEG5_LIMIT      = 16'hE000;
    localparam logic [19:0] ROM_MIRROR_MASK = 20'h7FFFF;
    localparam logic [7:0]  DSR_SEG_A       = 8'hF0;
    localparam logic [7:0]  DSR_SEG_B       = 8'h98;
    localparam logic [23:0] DATA_FOLD_MASK  = 24'h0FFFFF;
    localparam logic [23:0] FLASH_MARKER    = 24'h100000;
    localparam logic [15:0] CONST_OPEN      = 16'hFFFF;
    localparam logic [15:0] CONST_BYTE_OPEN = 16'h00FF;

    typedef struct packed {
        logic [2:0]  hw_model;
        logic        boot_remap;
        logic        segment_access;
        logic [20:0] rom_bytes;
        logic        real_hw_mode;
    } t_cfg;

    typedef struct packed {
        logic        corrupt_dsr;
        logic [15:0] const_value;
        logic [23:0] mem_address;
        logic [1:0]  source;
    } t_result;

endpackage

`default_nettype wire

>>> design/cad_decode.sv
// Combinational decode of one access into its source, address, constant and DSR flag.
// Depends on cad_pkg for codes, constants and the configuration and result structures.
`default_nettype none

module cad_decode
    import cad_pkg::*;
(
    input  wire t_cfg       i_cfg,
    input  wire logic [1:0] i_opcode,
    input  wire logic [23:0] i_address,
    output t_result         o_result
);

    logic [19:0] w_off;
    logic [3:0]  w_seg;
    logic [2:0]  w_seg7;
    logic [15:0] w_soff;
    logic [3:0]  w_seg_ti;
    logic [7:0]  w_dseg;

    // Result served from a memory or the bus
    function automatic t_result f_route(input logic [1:0] src, input logic [23:0] addr);
        t_result r;
        r             = '0;
        r.source      = src;
        r.mem_address = addr;
        return r;
    endfunction

    // Result given as a constant
    function automatic t_result f_const(input logic [15:0] value, input logic dsr);
        t_result r;
        r             = '0;
        r.source      = SRC_CONST;
        r.const_value = value;
        r.corrupt_dsr = dsr;
        return r;
    endfunction

    // Low ROM segments with optional boot remap; without remap the top of
    // segment 0 reads as open bus.
    function automatic t_result f_rom_low(input logic [19:0] off, input logic [3:0] seg,
                                          input logic [15:0] soff, input logic remap);
        logic [23:0] adj;
        t_result     r;
        adj = '0;
        if (remap) begin
            if (seg == 4'd0 && soff < BOOT_REMAP_SPAN) begin
                adj = {8'd0, BOOT_REMAP_OFS};
            end
            r = f_route(SRC_ROM, {4'd0, off} + adj);
        end else if (seg == 4'd0 && soff >= BOOT_REMAP_OFS) begin
            r = f_const(CONST_OPEN, 1'b0);
        end else begin
            r = f_route(SRC_ROM, {4'd0, off});
        end
        return r;
    endfunction

    // Field extraction for code and data addresses
    assign w_off    = i_address[19:0];
    assign w_seg    = w_off[19:16];
    assign w_seg7   = w_seg[2:0];
    assign w_soff   = {w_off[15:1], 1'b0};
    assign w_seg_ti = (i_cfg.segment_access && w_seg == 4'd5) ? 4'd0 : w_seg;
    assign w_dseg   = i_address[23:16];

    // Decode by access kind and hardware model
    always_comb begin
        o_result = f_const(16'd0, 1'b0);
        case (i_opcode)
            OP_FETCH: begin
                case (i_cfg.hw_model)
                    MDL_ESP: begin
                        if ({1'b0, w_off} < i_cfg.rom_bytes) begin
                            o_result = f_route(SRC_ROM, {4'd0, w_off});
                        end
                    end
                    MDL_TI, MDL_CWZ: begin
                        if (w_seg_ti < 4'd4) begin
                            o_result = f_rom_low(w_off, w_seg_ti, w_soff, i_cfg.boot_remap);
                        end
                    end
                    MDL_CWZ2: begin
                        if (w_seg == 4'd8) begin
                            o_result = f_route(SRC_ROM, {4'd0, w_off & ROM_MIRROR_MASK});
                        end else if (w_seg7 == 3'd7) begin
                            if (w_soff >= SEG7_LIMIT) begin
                                o_result = f_const(CONST_OPEN, 1'b0);
                            end else begin
                                o_result = f_route(SRC_ROM,
                                                   {4'd0, SEG7_ROM_BASE + {4'd0, w_soff}});
                            end
                        end else if (w_seg7 == 3'd5 && w_soff >= SEG5_LIMIT) begin
                            o_result = f_const(CONST_OPEN, 1'b0);
                        end else begin
                            o_result = f_rom_low(w_off, {1'b0, w_seg7}, w_soff,
                                                 i_cfg.boot_remap);
                        end
                    end
                    MDL_FLASH: begin
                        if (w_seg < 4'd2) begin
                            o_result = f_route(SRC_ROM, {4'd0, w_off});
                        end else if (w_seg >= 4'd8) begin
                            o_result = f_route(SRC_FLASH, {4'd0, w_off & ROM_MIRROR_MASK});
                        end else begin
                            o_result = f_const(CONST_OPEN, 1'b0);
                        end
                    end
                    default: begin
                        o_result = f_const(16'd0, 1'b0);
                    end
                endcase
            end
            OP_READ: begin
                // Unmapped segment folding of real classwiz_ii hardware
                if (i_cfg.hw_model == MDL_CWZ2 && i_cfg.real_hw_mode
                    && w_dseg >= 8'h10) begin
                    if (w_dseg == DSR_SEG_A || w_dseg == DSR_SEG_B) begin
                        o_result = f_const(16'd0, 1'b1);
                    end else if (w_dseg[2:0] > 3'd5) begin
                        if (i_address[1] || i_address[7:0] == 8'd0) begin
                            o_result = f_const(16'd0, 1'b0);
                        end else begin
                            o_result = f_const(CONST_BYTE_OPEN, 1'b0);
                        end
                    end else begin
                        o_result = f_route(SRC_BUS, i_address & DATA_FOLD_MASK);
                    end
                end else if (i_cfg.hw_model == MDL_FLASH && i_address == FLASH_MARKER) begin
                    o_result = f_const(CONST_BYTE_OPEN, 1'b0);
                end else begin
                    o_result = f_route(SRC_BUS, i_address);
                end
            end
            OP_WRITE: begin
                o_result = f_route(SRC_BUS, i_address);
            end
            default: begin
                o_result = f_const(16'd0, 1'b0);
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/calculator_address_decoder_core.sv
// An accepted beat is held in the input register, decoded combinationally and loaded into
// the result register once that frees, and can be taken on the output from there.
// Throughput: one access per cycle; an input register and a result register with
// a combinational decode between them, stalls propagating back through tready.
// Reset (synchronous, active low) empties both stages and restores the configuration
// registers; the configuration port is always ready. Depends on cad_pkg and cad_decode.
`default_nettype none

module calculator_address_decoder_core
    import cad_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Access stream in
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [23:0]            s_axis_tdata,  // [23:0] address
    input  wire logic [1:0]             s_axis_tuser,  // [1:0] opcode
    // Decoded result stream out
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [47:0]                 m_axis_tdata,  // [23:0] mem_address,
                                                       // [39:24] const_value,
                                                       // [40] corrupt_dsr, [47:41] zero
    output logic [1:0]                  m_axis_tuser   // [1:0] source
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic [1:0]  r_opcode;
    logic [23:0] r_address;
    logic        r_out_valid;
    t_result     r_result;
    t_result     w_result;
    logic        w_out_free;
    logic        n_in_valid;
    logic        n_out_valid;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hw_model       <= MDL_ESP;
            r_cfg.boot_remap     <= 1'b0;
            r_cfg.segment_access <= 1'b0;
            r_cfg.rom_bytes      <= ROM_BYTES_RESET;
            r_cfg.real_hw_mode   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HW_MODEL:       r_cfg.hw_model       <= i_cfg_data[2:0];
                REG_BOOT_REMAP:     r_cfg.boot_remap     <= i_cfg_data[0];
                REG_SEGMENT_ACCESS: r_cfg.segment_access <= i_cfg_data[0];
                REG_ROM_BYTES:      r_cfg.rom_bytes      <= i_cfg_data[20:0];
                REG_REAL_HW_MODE:   r_cfg.real_hw_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow control: the result register frees when empty or taken
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_out_free;

    always_comb begin
        n_in_valid  = s_axis_tready ? s_axis_tvalid : r_in_valid;
        n_out_valid = w_out_free ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_opcode  <= s_axis_tuser;
            r_address <= s_axis_tdata;
        end
    end

    // Decode between the two registers
    cad_decode u_decode (
        .i_cfg     (r_cfg),
        .i_opcode  (r_opcode),
        .i_address (r_address),
        .o_result  (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_out_free && r_in_valid) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_result.source;
    assign m_axis_tdata  = {7'd0, r_result.corrupt_dsr, r_result.const_value,
                            r_result.mem_address};

    // A constant result presents no address
    a_const_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.source == SRC_CONST) |-> (r_result.mem_address == 24'd0))
        else $error("constant result carries an address");

    // A routed result carries no constant
    a_route_no_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.source != SRC_CONST) |-> (r_result.const_value == 16'd0))
        else $error("routed result carries a constant value");

    // The DSR flag only comes with a zero constant
    a_dsr_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.corrupt_dsr)
        |-> (r_result.source == SRC_CONST && r_result.const_value == 16'd0))
        else $error("DSR corruption outside the zero constant case");

    // A held input stage keeps its access while the result stage is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_address)
                                         && $stable(r_opcode)))
        else $error("input stage lost its access during a stall");

    // Input is refused only when both stages are full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid))
        else $error("input refused with a free stage");

endmodule

`default_nettype wire
